FILE: rtl/cfd_pkg.sv
package cfd_pkg;

  localparam int unsigned POS_W       = 10;
  localparam int unsigned HDR_LEN     = 20;
  localparam int unsigned TRAILER_LEN = 2;
  localparam int unsigned HDR_IDX_W   = 5;
  localparam int unsigned CRC_FEED_POS = 4;
  localparam int unsigned HDR_CRC_POS  = 19;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [POS_W-1:0] POS_MAX  = '1;
  localparam logic [7:0]       SYNC0    = 8'h55;
  localparam logic [7:0]       SYNC1    = 8'hAA;
  localparam logic [7:0]       VERSION  = 8'h01;
  localparam logic [15:0]      CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_LEN_MISMATCH = 3'd1,
    ST_SHORT        = 3'd2,
    ST_BAD_HDR      = 3'd3,
    ST_CRC_ERR      = 3'd4
  } status_e;

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [7:0]           data;
    logic                 last;
    logic                 first;
    logic                 feed;
    logic                 snap;
    logic                 hdr_wr;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic                 short_buf;
    logic [POS_W-1:0]     pos;
  } item_t;

  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/cfd_front.sv
module cfd_front
  import cfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output item_t       q_item_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             accept;

  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i;
  assign accept     = in_valid_i && q_ready_i;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (last_byte_i) begin
        pos_d = '0;
      end else if (pos_q != POS_MAX) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_comb begin
    q_item_o.data      = data_byte_i;
    q_item_o.last      = last_byte_i;
    q_item_o.first     = (pos_q == '0);
    q_item_o.feed      = (pos_q >= POS_W'(CRC_FEED_POS));
    q_item_o.snap      = (pos_q == POS_W'(HDR_CRC_POS));
    q_item_o.hdr_wr    = (pos_q < POS_W'(HDR_LEN));
    q_item_o.hdr_idx   = pos_q[HDR_IDX_W-1:0];
    // buffer length below header plus trailer
    q_item_o.short_buf = (pos_q < POS_W'(HDR_LEN + TRAILER_LEN - 1));
    q_item_o.pos       = pos_q;
  end

endmodule

FILE: rtl/cfd_queue.sv
module cfd_queue
  import cfd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/cfd_back.sv
module cfd_back
  import cfd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 490
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] crc_init_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  item_t       q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  frame_type_o,
  output logic [7:0]  frame_flags_o,
  output logic [15:0] seq_num_o,
  output logic [15:0] ack_seq_num_o,
  output logic [15:0] command_o,
  output logic [8:0]  payload_length_o,
  output logic [31:0] session_tag_o
);

  logic [7:0]  hdr_q [HDR_LEN];
  logic [15:0] crc_q, crc_d, crc_base;
  logic [15:0] snap_q, pend_q;
  logic        out_valid_q;
  logic        pop, done;

  status_e     status_q, status_d;
  logic [7:0]  type_q, flags_q;
  logic [15:0] seq_q, ack_q, cmd_q;
  logic [8:0]  plen_q;
  logic [31:0] sid_q;

  logic [15:0] plen, hdr_crc, rx_crc;
  logic [16:0] len, len_exp;
  logic        hdr_bad;

  assign q_ready_o = !q_item_i.last || !out_valid_q || out_ready_i;
  assign pop       = q_valid_i && q_ready_o;
  assign done      = pop && q_item_i.last;

  always_comb begin
    crc_base = q_item_i.first ? crc_init_i : crc_q;
    crc_d    = q_item_i.feed ? crc16_feed(crc_base, pend_q[15:8]) : crc_base;
  end

  // trailing frame CRC is little-endian
  assign rx_crc  = {q_item_i.data, pend_q[7:0]};
  assign plen    = {hdr_q[13], hdr_q[12]};
  assign hdr_crc = {hdr_q[19], hdr_q[18]};
  assign len     = 17'(q_item_i.pos) + 17'd1;
  assign len_exp = 17'(HDR_LEN + TRAILER_LEN) + 17'(plen);
  assign hdr_bad = (hdr_q[0] != SYNC0) || (hdr_q[1] != SYNC1) ||
                   (hdr_q[2] != VERSION) || (hdr_q[5] != 8'(HDR_LEN));

  always_comb begin
    priority if (q_item_i.short_buf) begin
      status_d = ST_SHORT;
    end else if (hdr_bad) begin
      status_d = ST_BAD_HDR;
    end else if (plen > 16'(MAX_PAYLOAD)) begin
      status_d = ST_SHORT;
    end else if (len != len_exp) begin
      status_d = ST_LEN_MISMATCH;
    end else if (hdr_crc != snap_q) begin
      status_d = ST_CRC_ERR;
    end else if (rx_crc != crc_d) begin
      status_d = ST_CRC_ERR;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_item_i.hdr_wr) begin
      hdr_q[q_item_i.hdr_idx] <= q_item_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= 16'hFFFF;
      snap_q <= '0;
      pend_q <= '0;
    end else if (pop) begin
      if (q_item_i.last) begin
        crc_q  <= crc_init_i;
        snap_q <= '0;
        pend_q <= '0;
      end else begin
        crc_q  <= crc_d;
        pend_q <= {pend_q[7:0], q_item_i.data};
        if (q_item_i.snap) begin
          snap_q <= crc_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q <= status_d;
      if (status_d == ST_OK) begin
        type_q  <= hdr_q[3];
        flags_q <= hdr_q[4];
        seq_q   <= {hdr_q[7], hdr_q[6]};
        ack_q   <= {hdr_q[9], hdr_q[8]};
        cmd_q   <= {hdr_q[11], hdr_q[10]};
        plen_q  <= plen[8:0];
        sid_q   <= {hdr_q[17], hdr_q[16], hdr_q[15], hdr_q[14]};
      end else begin
        type_q  <= '0;
        flags_q <= '0;
        seq_q   <= '0;
        ack_q   <= '0;
        cmd_q   <= '0;
        plen_q  <= '0;
        sid_q   <= '0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign frame_type_o     = type_q;
  assign frame_flags_o    = flags_q;
  assign seq_num_o        = seq_q;
  assign ack_seq_num_o    = ack_q;
  assign command_o        = cmd_q;
  assign payload_length_o = plen_q;
  assign session_tag_o    = sid_q;

endmodule

FILE: rtl/crc_checked_frame_deframer_unit.sv
// Results register when the back end pops a last byte, which waits for a free output.
// Throughput: one byte per cycle but for that wait; the byte-wide CRC-16 update sets it.
// A finished result waits in the output register; payload bytes keep flowing meanwhile.
// Reset: asynchronous, active low; crc_init returns to 0xFFFF, position and queue clear.
// The header store holds no reset value; each buffer rewrites the header bytes it carries.
module crc_checked_frame_deframer_unit
  import cfd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 490
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        crc_init_we_i,
  input  logic [15:0] crc_init_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  frame_type_o,
  output logic [7:0]  frame_flags_o,
  output logic [15:0] seq_num_o,
  output logic [15:0] ack_seq_num_o,
  output logic [15:0] command_o,
  output logic [8:0]  payload_length_o,
  output logic [31:0] session_tag_o
);

  logic [15:0] crc_init_q;
  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  item_t       fq_item, bq_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_init_q <= 16'hFFFF;
    end else if (crc_init_we_i) begin
      crc_init_q <= crc_init_i;
    end
  end

  cfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_valid_o   (fq_valid),
    .q_ready_i   (fq_ready),
    .q_item_o    (fq_item)
  );

  cfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_item_i  (fq_item),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_item_o   (bq_item)
  );

  cfd_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .crc_init_i       (crc_init_q),
    .q_valid_i        (bq_valid),
    .q_ready_o        (bq_ready),
    .q_item_i         (bq_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .frame_type_o     (frame_type_o),
    .frame_flags_o    (frame_flags_o),
    .seq_num_o        (seq_num_o),
    .ack_seq_num_o    (ack_seq_num_o),
    .command_o        (command_o),
    .payload_length_o (payload_length_o),
    .session_tag_o    (session_tag_o)
  );

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (frame_type_o == '0 && frame_flags_o == '0 && seq_num_o == '0 &&
       ack_seq_num_o == '0 && command_o == '0 && payload_length_o == '0 &&
       session_tag_o == '0))
    else $error("failed frame carries header fields");

  a_ok_plen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |->
      ({7'd0, payload_length_o} <= 16'(MAX_PAYLOAD)) || (MAX_PAYLOAD > 511))
    else $error("accepted frame exceeds payload limit");

  a_last_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bq_valid && bq_ready && bq_item.last) |=> out_valid_o)
    else $error("completed buffer produced no result");

endmodule
